[hw/rtl/pnpa_pkg.sv]
`default_nettype none
package pnpa_pkg;

	localparam int unsigned PATCH_SIDE   = 16;
	localparam int unsigned PATCH_BUDGET = 256;
	localparam int unsigned CHANNELS     = 3;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned PNUM_W   = 16;
	localparam int unsigned PIX_W    = 8;
	localparam int unsigned SUB_W    = 4;   // column / row inside a patch
	localparam int unsigned PCNT_W   = 8;   // patch column / patch row
	localparam int unsigned COUNT_W  = 9;   // patches_across / patches_down
	localparam int unsigned PROD_W   = BYTE_W + 1 + VALUE_W;
	localparam int unsigned SUM_W    = PROD_W + 1;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W    = 32;

	localparam logic [SUB_W-1:0]  SIDE_LAST = SUB_W'(PATCH_SIDE - 1);
	localparam logic [PIX_W-1:0]  PIX_LAST  = PIX_W'(PATCH_SIDE * PATCH_SIDE - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(256);

	localparam logic signed [VALUE_W-1:0] GAIN_RESET   = 32'sd514;
	localparam logic signed [VALUE_W-1:0] OFFSET_RESET = -32'sd65536;
	localparam logic [COUNT_W-1:0]        COUNT_RESET  = 9'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_GAIN      = 3'd0,
		REG_GREEN_GAIN    = 3'd1,
		REG_BLUE_GAIN     = 3'd2,
		REG_RED_OFFSET    = 3'd3,
		REG_GREEN_OFFSET  = 3'd4,
		REG_BLUE_OFFSET   = 3'd5,
		REG_PATCHES_ACROSS = 3'd6,
		REG_PATCHES_DOWN  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [PNUM_W-1:0] patch_number;
		logic [PIX_W-1:0]  pixel_in_patch;
		logic              kept;
		logic              last_pixel;
	} pnpa_meta_t;

	// last counter value for a patch count; zero acts as one, above range as 256
	function automatic logic [PCNT_W-1:0] count_last(input logic [COUNT_W-1:0] r);
		logic [PCNT_W-1:0] m;
		if (r == '0)
			m = '0;
		else if (r > COUNT_MAX)
			m = PCNT_W'(COUNT_MAX - COUNT_W'(1));
		else
			m = PCNT_W'(r - COUNT_W'(1));
		return m;
	endfunction

	function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [SUM_W-1:0] s);
		logic signed [VALUE_W-1:0] v;
		if (s[SUM_W-1:VALUE_W-1] == '0 || s[SUM_W-1:VALUE_W-1] == '1)
			v = s[VALUE_W-1:0];
		else if (s[SUM_W-1])
			v = {1'b1, {(VALUE_W-1){1'b0}}};
		else
			v = {1'b0, {(VALUE_W-1){1'b1}}};
		return v;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/pnpa_if.sv]
`default_nettype none
interface pnpa_pix_if import pnpa_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] red_byte;
	logic [BYTE_W-1:0] green_byte;
	logic [BYTE_W-1:0] blue_byte;

	modport source (output valid, output red_byte, output green_byte, output blue_byte,
		input ready);
	modport sink (input valid, input red_byte, input green_byte, input blue_byte,
		output ready);
endinterface

interface pnpa_res_if import pnpa_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] red_value;
	logic signed [VALUE_W-1:0] green_value;
	logic signed [VALUE_W-1:0] blue_value;
	logic [PNUM_W-1:0]         patch_number;
	logic [PIX_W-1:0]          pixel_in_patch;
	logic                      kept;
	logic                      last_pixel;

	modport source (output valid, output red_value, output green_value, output blue_value,
		output patch_number, output pixel_in_patch, output kept, output last_pixel,
		input ready);
	modport sink (input valid, input red_value, input green_value, input blue_value,
		input patch_number, input pixel_in_patch, input kept, input last_pixel,
		output ready);
endinterface
`default_nettype wire

[hw/rtl/pixel_normalize_patch_addresser.sv]
// Path: an accepted item reaches its result through the pipeline registers
// (input register, then multiply, offset add and saturate into the result register).
// Throughput: one item per cycle; the input is held off only while both registers
// hold an item and the result is not taken.
// Reset (arst_n low, asynchronous): pipeline empty, counters at zero, gains 514,
// offsets -1.0 in Q16.16, 16 x 16 patches.
`default_nettype none
module pixel_normalize_patch_addresser import pnpa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	pnpa_pix_if.sink                  pix_in,
	pnpa_res_if.source                res_out,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// configuration
	logic signed [VALUE_W-1:0] gain_q [CHANNELS];
	logic signed [VALUE_W-1:0] offset_q [CHANNELS];
	logic [COUNT_W-1:0]        across_q;
	logic [COUNT_W-1:0]        down_q;

	// raster position
	logic [SUB_W-1:0]  col_in_patch_q;
	logic [PCNT_W-1:0] patch_col_q;
	logic [SUB_W-1:0]  row_in_patch_q;
	logic [PCNT_W-1:0] patch_row_q;
	logic [PNUM_W-1:0] row_base_q;

	// pipeline
	logic                      valid_s1, valid_s2;
	logic [BYTE_W-1:0]         byte_s1 [CHANNELS];
	pnpa_meta_t                meta_s1, meta_s2;
	logic signed [PROD_W-1:0]  prod [CHANNELS];
	logic signed [VALUE_W-1:0] value_s2 [CHANNELS];

	logic        load_s2, load_s1, accept;
	logic [PCNT_W-1:0] across_last, down_last;
	logic [COUNT_W-1:0] across_eff;
	logic        col_end, pcol_end, row_end, prow_end;
	pnpa_meta_t  meta_now;
	logic [BYTE_W-1:0] byte_in [CHANNELS];

	// Stall chain: a stage loads when it is empty or moving on.
	assign load_s2 = !valid_s2 || res_out.ready;
	assign load_s1 = !valid_s1 || load_s2;
	assign pix_in.ready = load_s1;
	assign accept = pix_in.valid && load_s1;

	assign byte_in[0] = pix_in.red_byte;
	assign byte_in[1] = pix_in.green_byte;
	assign byte_in[2] = pix_in.blue_byte;

	// Counter ends; a counter past its last value (count changed mid image)
	// counts as at its last value.
	always_comb begin
		across_last = count_last(across_q);
		down_last   = count_last(down_q);
		across_eff  = {1'b0, across_last} + COUNT_W'(1);
		col_end  = col_in_patch_q >= SIDE_LAST;
		pcol_end = patch_col_q >= across_last;
		row_end  = row_in_patch_q >= SIDE_LAST;
		prow_end = patch_row_q >= down_last;
		meta_now.patch_number   = row_base_q + PNUM_W'(patch_col_q);
		meta_now.pixel_in_patch = PIX_W'(PIX_W'(row_in_patch_q) * PIX_W'(PATCH_SIDE))
			+ PIX_W'(col_in_patch_q);
		meta_now.kept = {1'b0, meta_now.patch_number} < (PNUM_W+1)'(PATCH_BUDGET);
		meta_now.last_pixel = col_end && pcol_end && row_end && prow_end;
	end

	// 9x32 signed product of the held byte and its gain
	always_comb begin
		for (int c = 0; c < CHANNELS; c++)
			prod[c] = $signed({1'b0, byte_s1[c]}) * gain_q[c];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				gain_q[c]   <= GAIN_RESET;
				offset_q[c] <= OFFSET_RESET;
			end
			across_q <= COUNT_RESET;
			down_q   <= COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_RED_GAIN:       gain_q[0]   <= cfg_data;
				REG_GREEN_GAIN:     gain_q[1]   <= cfg_data;
				REG_BLUE_GAIN:      gain_q[2]   <= cfg_data;
				REG_RED_OFFSET:     offset_q[0] <= cfg_data;
				REG_GREEN_OFFSET:   offset_q[1] <= cfg_data;
				REG_BLUE_OFFSET:    offset_q[2] <= cfg_data;
				REG_PATCHES_ACROSS: across_q    <= cfg_data[COUNT_W-1:0];
				REG_PATCHES_DOWN:   down_q      <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// raster counters, stepped once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_in_patch_q <= '0;
			patch_col_q    <= '0;
			row_in_patch_q <= '0;
			patch_row_q    <= '0;
			row_base_q     <= '0;
		end else if (accept) begin
			if (!col_end) begin
				col_in_patch_q <= col_in_patch_q + SUB_W'(1);
			end else begin
				col_in_patch_q <= '0;
				if (!pcol_end) begin
					patch_col_q <= patch_col_q + PCNT_W'(1);
				end else begin
					patch_col_q <= '0;
					if (!row_end) begin
						row_in_patch_q <= row_in_patch_q + SUB_W'(1);
					end else begin
						row_in_patch_q <= '0;
						if (!prow_end) begin
							patch_row_q <= patch_row_q + PCNT_W'(1);
							row_base_q  <= row_base_q + PNUM_W'(across_eff);
						end else begin
							patch_row_q <= '0;
							row_base_q  <= '0;
						end
					end
				end
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= pix_in.valid;
			if (load_s2)
				valid_s2 <= valid_s1;
		end
	end

	// payload: input register, then product, offset add and saturate
	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_now;
			for (int c = 0; c < CHANNELS; c++)
				byte_s1[c] <= byte_in[c];
		end
		if (load_s2 && valid_s1) begin
			meta_s2 <= meta_s1;
			for (int c = 0; c < CHANNELS; c++)
				value_s2[c] <= sat32(SUM_W'(prod[c]) + SUM_W'(offset_q[c]));
		end
	end

	assign res_out.valid          = valid_s2;
	assign res_out.red_value      = value_s2[0];
	assign res_out.green_value    = value_s2[1];
	assign res_out.blue_value     = value_s2[2];
	assign res_out.patch_number   = meta_s2.patch_number;
	assign res_out.pixel_in_patch = meta_s2.pixel_in_patch;
	assign res_out.kept           = meta_s2.kept;
	assign res_out.last_pixel     = meta_s2.last_pixel;

endmodule
`default_nettype wire

[hw/rtl/pnpa_checker.sv]
`default_nettype none
module pnpa_checker import pnpa_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [PNUM_W-1:0] patch_number,
	input wire logic [PIX_W-1:0]  pixel_in_patch,
	input wire logic              kept,
	input wire logic              last_pixel
);

	// reset empties the output
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// a held result keeps its address fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(patch_number)
		&& $stable(pixel_in_patch) && $stable(last_pixel))
		else $error("stalled result changed");

	// input only backs off behind a stalled output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without output stall");

	a_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kept == ({1'b0, patch_number} < (PNUM_W+1)'(PATCH_BUDGET)))
		else $error("kept flag disagrees with patch number");

	// the image ends on the bottom-right pixel of a patch
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> pixel_in_patch == PIX_LAST)
		else $error("last pixel not at patch corner");

endmodule

bind pixel_normalize_patch_addresser pnpa_checker u_pnpa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (pix_in.ready),
	.out_valid      (res_out.valid),
	.out_ready      (res_out.ready),
	.patch_number   (res_out.patch_number),
	.pixel_in_patch (res_out.pixel_in_patch),
	.kept           (res_out.kept),
	.last_pixel     (res_out.last_pixel)
);
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
// Checks pixel normalisation, saturation and patch addressing item by item against
// an in-bench predictor of the same arithmetic and counters.
module tb_top;
	import pnpa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int CHUNK_ITEMS  = 110;
	localparam int FINAL_ITEMS  = 80;
	localparam longint VAL_MAX  = 64'sd2147483647;
	localparam longint VAL_MIN  = -64'sd2147483648;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] red;
		logic signed [VALUE_W-1:0] green;
		logic signed [VALUE_W-1:0] blue;
		logic [PNUM_W-1:0]         patch_number;
		logic [PIX_W-1:0]          pixel_in_patch;
		logic                      kept;
		logic                      last_pixel;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	pnpa_pix_if pix_if();
	pnpa_res_if res_if();

	pixel_normalize_patch_addresser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_if),
		.res_out   (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// pixels waiting to be offered, and results owed by the block
	rgb_t          pixel_todo_q[$];
	pixel_result_t pixel_expect_q[$];

	int items_sent;
	int results_checked = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int lost_items;
	int send_idle_pct;
	int recv_idle_pct;

	// receiver hold-off for the back-pressure stretch
	logic hold_request;
	int   hold_left = 0;

	logic pix_taken = 1'b0;

	// shadow of the block's registers
	logic signed [VALUE_W-1:0] gain_r [CHANNELS];
	logic signed [VALUE_W-1:0] offset_r [CHANNELS];
	logic [COUNT_W-1:0]        across_r;
	logic [COUNT_W-1:0]        down_r;

	// shadow of the raster counters
	logic [SUB_W-1:0]  col_in = '0;
	logic [PCNT_W-1:0] patch_col = '0;
	logic [SUB_W-1:0]  row_in = '0;
	logic [PCNT_W-1:0] patch_row = '0;
	logic [PNUM_W-1:0] row_base = '0;

	// index of the last patch for a count register: 0 behaves as 1, over 256 as 256
	function automatic logic [PCNT_W-1:0] top_index(input logic [COUNT_W-1:0] r);
		if (r == '0)
			return '0;
		if (r > 9'd256)
			return 8'd255;
		return PCNT_W'(r - 9'd1);
	endfunction

	// byte * Q16.16 gain + Q16.16 offset, exact, clamped to 32 bits
	function automatic logic signed [VALUE_W-1:0] scale_channel(input logic [BYTE_W-1:0] b,
			input logic signed [VALUE_W-1:0] g, input logic signed [VALUE_W-1:0] o);
		longint s;
		s = longint'(b) * longint'(g) + longint'(o);
		if (s > VAL_MAX)
			return 32'sh7fff_ffff;
		if (s < VAL_MIN)
			return 32'sh8000_0000;
		return VALUE_W'(s);
	endfunction

	// Works out the result for one accepted pixel and steps the raster counters.
	// A counter at or past its last value is treated as at its last value, which
	// covers counts shrunk in the middle of an image.
	task automatic predict_pixel(input rgb_t px);
		pixel_result_t r;
		logic [PCNT_W-1:0] across_last;
		logic [PCNT_W-1:0] down_last;
		logic col_end, pcol_end, row_end, prow_end;
		across_last = top_index(across_r);
		down_last   = top_index(down_r);
		col_end  = col_in >= SIDE_LAST;
		pcol_end = patch_col >= across_last;
		row_end  = row_in >= SIDE_LAST;
		prow_end = patch_row >= down_last;

		r.red            = scale_channel(px.red, gain_r[0], offset_r[0]);
		r.green          = scale_channel(px.green, gain_r[1], offset_r[1]);
		r.blue           = scale_channel(px.blue, gain_r[2], offset_r[2]);
		r.patch_number   = row_base + PNUM_W'(patch_col);
		r.pixel_in_patch = PIX_W'(row_in * PATCH_SIDE + col_in);
		r.kept           = r.patch_number < PATCH_BUDGET;
		r.last_pixel     = col_end && pcol_end && row_end && prow_end;
		pixel_expect_q.push_back(r);

		if (!col_end) begin
			col_in = col_in + 1'b1;
		end else begin
			col_in = '0;
			if (!pcol_end) begin
				patch_col = patch_col + 1'b1;
			end else begin
				patch_col = '0;
				if (!row_end) begin
					row_in = row_in + 1'b1;
				end else begin
					row_in = '0;
					if (!prow_end) begin
						patch_row = patch_row + 1'b1;
						row_base  = row_base + PNUM_W'(across_last) + 1'b1;
					end else begin
						patch_row = '0;
						row_base  = '0;
					end
				end
			end
		end
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %h got %h", results_checked, field, want, got);
		end
	endtask

	// Register write at the falling edge; the shadow follows at once, which is
	// safe because writes only happen with nothing in flight.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_RED_GAIN:       gain_r[0] = data;
			REG_GREEN_GAIN:     gain_r[1] = data;
			REG_BLUE_GAIN:      gain_r[2] = data;
			REG_RED_OFFSET:     offset_r[0] = data;
			REG_GREEN_OFFSET:   offset_r[1] = data;
			REG_BLUE_OFFSET:    offset_r[2] = data;
			REG_PATCHES_ACROSS: across_r = data[COUNT_W-1:0];
			REG_PATCHES_DOWN:   down_r = data[COUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly random, with the saturating and zero corners now and then
	function automatic logic [CFG_W-1:0] pick_word();
		logic [CFG_W-1:0] w;
		case ($urandom_range(7))
			0: w = 32'h7fff_ffff;
			1: w = 32'h8000_0000;
			2: w = '0;
			3: w = $urandom_range(131072);
			4: w = -$urandom_range(131072);
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// mostly one patch each way so that whole images go by often
	function automatic logic [COUNT_W-1:0] pick_count();
		logic [COUNT_W-1:0] c;
		case ($urandom_range(9))
			0: c = '0;
			1: c = 9'd256;
			2: c = COUNT_W'($urandom_range(257, 511));
			3: c = COUNT_W'($urandom_range(2, 6));
			default: c = 9'd1;
		endcase
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	task automatic queue_rgb(input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
			input logic [BYTE_W-1:0] b);
		rgb_t px;
		px = '{red: r, green: g, blue: b};
		pixel_todo_q.push_back(px);
		items_sent++;
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			queue_rgb(pick_byte(), pick_byte(), pick_byte());
	endtask

	// count registers carry random junk above bit 8, which the block must drop
	task automatic random_setup();
		logic [CFG_W-1:0] d;
		write_reg(REG_RED_GAIN, pick_word());
		write_reg(REG_GREEN_GAIN, pick_word());
		write_reg(REG_BLUE_GAIN, pick_word());
		write_reg(REG_RED_OFFSET, pick_word());
		write_reg(REG_GREEN_OFFSET, pick_word());
		write_reg(REG_BLUE_OFFSET, pick_word());
		d = $urandom;
		d[COUNT_W-1:0] = pick_count();
		write_reg(REG_PATCHES_ACROSS, d);
		d = $urandom;
		d[COUNT_W-1:0] = pick_count();
		write_reg(REG_PATCHES_DOWN, d);
	endtask

	// every item gives exactly one result, so matched results tell when all is out
	task automatic wait_drained();
		while (results_checked != items_sent)
			@(negedge clk);
	endtask

	// Sender: a new item is offered only once the current one has gone.
	always @(negedge clk) begin : drive
		rgb_t px;
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
		end else if (!pix_if.valid || pix_taken) begin
			if (pixel_todo_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				px = pixel_todo_q.pop_front();
				pix_if.valid      <= 1'b1;
				pix_if.red_byte   <= px.red;
				pix_if.green_byte <= px.green;
				pix_if.blue_byte  <= px.blue;
			end else begin
				pix_if.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, and none at all-ready while the long hold-off runs.
	always @(negedge clk)
		res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (hold_request)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Both handshakes sampled at the rising edge. Results are checked before the
	// new item is predicted, though the pipeline delay keeps them apart anyway.
	always @(posedge clk) begin : watch
		pixel_result_t want;
		if (!arst_n) begin
			pix_taken <= 1'b0;
		end else begin
			pix_taken <= pix_if.valid && pix_if.ready;
			if (res_if.valid && res_if.ready) begin
				if (pixel_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result item with nothing expected: patch %0d pixel %0d",
							res_if.patch_number, res_if.pixel_in_patch);
				end else begin
					want = pixel_expect_q.pop_front();
					compare_field("red_value", want.red, res_if.red_value);
					compare_field("green_value", want.green, res_if.green_value);
					compare_field("blue_value", want.blue, res_if.blue_value);
					compare_field("patch_number", want.patch_number, res_if.patch_number);
					compare_field("pixel_in_patch", want.pixel_in_patch, res_if.pixel_in_patch);
					compare_field("kept", want.kept, res_if.kept);
					compare_field("last_pixel", want.last_pixel, res_if.last_pixel);
					results_checked++;
				end
			end
			if (pix_if.valid && pix_if.ready)
				predict_pixel('{red: pix_if.red_byte, green: pix_if.green_byte,
					blue: pix_if.blue_byte});
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_RED_GAIN;
		cfg_data          = '0;
		hold_request      = 1'b0;
		items_sent        = 0;
		lost_items        = 0;
		for (int c = 0; c < CHANNELS; c++) begin
			gain_r[c]   = GAIN_RESET;
			offset_r[c] = OFFSET_RESET;
		end
		across_r  = COUNT_RESET;
		down_r    = COUNT_RESET;

		// sender idles a little, receiver a lot
		send_idle_pct = 14;
		recv_idle_pct = 53;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Reset values: gain 514, offset -1.0, 16 x 16 patches. Byte extremes.
		queue_rgb(8'h00, 8'h00, 8'h00);
		queue_rgb(8'hff, 8'hff, 8'hff);
		queue_rgb(8'h80, 8'h01, 8'hfe);
		wait_drained();

		// Saturation both ways: red pinned at the top, green at the bottom, blue
		// passes the offset straight through. Across of zero acts as one, down of
		// 257 as 256; junk above bit 8 must be ignored.
		write_reg(REG_RED_GAIN, 32'h7fff_ffff);
		write_reg(REG_GREEN_GAIN, 32'h8000_0000);
		write_reg(REG_BLUE_GAIN, 32'h0000_0000);
		write_reg(REG_RED_OFFSET, 32'h7fff_ffff);
		write_reg(REG_GREEN_OFFSET, 32'h8000_0000);
		write_reg(REG_BLUE_OFFSET, 32'h0000_0000);
		write_reg(REG_PATCHES_ACROSS, 32'habcd_e000);
		write_reg(REG_PATCHES_DOWN, 32'h0000_0101);
		queue_rgb(8'h00, 8'h00, 8'h00);
		queue_rgb(8'hff, 8'hff, 8'hff);
		queue_rgb(8'h01, 8'h01, 8'h01);
		queue_rgb(8'hff, 8'h00, 8'h80);
		wait_drained();

		// Across above range acts as 256, down of zero as one. Enough pixels to
		// step into the next patch column, so the first random setup with a small
		// across starts with the column counter past its last value.
		write_reg(REG_RED_GAIN, -32'sd514);
		write_reg(REG_GREEN_GAIN, 32'h0001_0000);
		write_reg(REG_BLUE_GAIN, 32'h0000_0001);
		write_reg(REG_RED_OFFSET, 32'h0000_0000);
		write_reg(REG_GREEN_OFFSET, 32'h0000_8000);
		write_reg(REG_BLUE_OFFSET, 32'hffff_ffff);
		write_reg(REG_PATCHES_ACROSS, 32'h0000_01ff);
		write_reg(REG_PATCHES_DOWN, 32'hffff_fe00);
		queue_random(10);
		wait_drained();

		// Random chunks, fresh registers each time; the idling pattern flips after two
		// chunks and then stops for the last two.
		for (int chunk = 0; chunk < 6; chunk++) begin
			case (chunk / 2)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 53;
				end
				1: begin
					send_idle_pct = 53;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			random_setup();
			queue_random(CHUNK_ITEMS);
			wait_drained();
		end

		// Wide patch rows so the patch column climbs through many patches.
		write_reg(REG_PATCHES_ACROSS, 32'd256);
		write_reg(REG_PATCHES_DOWN, 32'd2);
		queue_random(FINAL_ITEMS);

		// long receiver stall while the sender keeps offering, to fill the pipe
		@(negedge clk);
		hold_request <= 1'b1;
		@(negedge clk);
		hold_request <= 1'b0;
		wait_drained();

		// keep the clock running to catch any stray result
		repeat (8) @(posedge clk);
		lost_items = pixel_expect_q.size();
		if (lost_items != 0)
			$display("%0d result items never arrived", lost_items);
		if (mismatches == 0 && lost_items == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

[pixel_normalize_patch_addresser.f]
hw/rtl/pnpa_pkg.sv
hw/rtl/pnpa_if.sv
hw/rtl/pixel_normalize_patch_addresser.sv
hw/rtl/pnpa_checker.sv
tb/tb_top.sv
